/* rtl/core/itda_pkg.sv */
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

	// Width of the value taken from the input word (8 to 64)
	localparam int DATA_WIDTH = 64;
	// Width of the value port
	localparam int VALUE_W    = 64;
	// Decimal digits held by the converter (enough for 2^64 - 1)
	localparam int NUM_DIGITS = 20;
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
	localparam int BIT_CNT_W  = $clog2(DATA_WIDTH + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// Packed BCD digits, index 0 is the least significant digit
	typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

	// Sequencer commands to the conversion unit
	typedef struct packed {
		logic load;
		logic step;
	} dab_ctl_t;

endpackage

/* rtl/core/int_to_decimal_ascii_top.sv */
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Converts one integer into its decimal ASCII string, one character a word.
// ----------------------------------------------------------------------------
// Before the first character strobes, a value passes through 64 conversion
// steps of the shift-add-3 unit, one digit scan and one output register.
// A new value is taken only once the block is idle; each value gives 1..21 characters.
// Characters follow back to back, one per cycle; the receiver cannot stall.
// Reset clears the sequencer and the strobe; no state crosses values.
module int_to_decimal_ascii_top import itda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic               signed_mode,
	input  logic               minus_flag,
	output logic               strobe,
	output logic [7:0]         char_code,
	output logic               last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [DIG_IDX_W-1:0]  dig_idx_q;
	logic                  neg_q;
	logic                  sign_pend_q;
	logic                  strobe_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic                  accept;
	logic [DATA_WIDTH-1:0] raw;
	logic                  is_neg;
	logic [DATA_WIDTH-1:0] mag;
	dab_ctl_t              ctl;
	bcd_t                  bcd;
	logic [DIG_IDX_W-1:0]  top_idx;
	logic [3:0]            cur_digit;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Take magnitude of a negative signed value
	assign raw    = value[DATA_WIDTH-1:0];
	assign is_neg = signed_mode && raw[DATA_WIDTH-1];
	assign mag    = is_neg ? (~raw + DATA_WIDTH'(1)) : raw;

	assign ctl = '{load: accept, step: (state_q == ST_CONV)};

	itda_dabble u_dabble (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.load_value (mag),
		.bcd        (bcd)
	);

	// Find the most significant nonzero digit; zero value keeps index 0
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[i] != 4'd0) begin
				top_idx = DIG_IDX_W'(i);
			end
		end
	end

	assign cur_digit = bcd[dig_idx_q];

	// Sequence load, conversion, scan and character output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_cnt_q   <= '0;
			dig_idx_q   <= '0;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q     <= minus_flag || is_neg;
						bit_cnt_q <= BIT_CNT_W'(DATA_WIDTH);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					dig_idx_q   <= top_idx;
					sign_pend_q <= neg_q;
					state_q     <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (sign_pend_q) begin
						sign_pend_q <= 1'b0;
					end else if (dig_idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						dig_idx_q <= dig_idx_q - DIG_IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Register the outgoing character word
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			if (sign_pend_q) begin
				char_q <= CHAR_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= CHAR_ZERO + {4'd0, cur_digit};
				last_q <= (dig_idx_q == '0);
			end
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

/* rtl/core/itda_dabble.sv */
// ----------------------------------------------------------------------------
// itda_dabble
// Shift-and-add-3 binary to BCD unit: one input bit is folded into the
// decimal digits on each step command.
// ----------------------------------------------------------------------------
module itda_dabble import itda_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dab_ctl_t              ctl,
	input  logic [DATA_WIDTH-1:0] load_value,
	output bcd_t                  bcd
);

	logic [DATA_WIDTH-1:0] bin_q;
	bcd_t                  bcd_q;
	bcd_t                  adj;

	// Correct every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// Load clears the digits; step shifts the next bit in, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (ctl.load) begin
			bin_q <= load_value;
			bcd_q <= '0;
		end else if (ctl.step) begin
			bin_q <= {bin_q[DATA_WIDTH-2:0], 1'b0};
			// top bit of the top digit never carries for a 64-bit value
			bcd_q <= bcd_t'({adj, bin_q[DATA_WIDTH-1]});
		end
	end

	assign bcd = bcd_q;

endmodule

/* rtl/core/itda_checker.sv */
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module itda_checker import itda_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] char_code,
	input logic       last
);

	// Accepted value holds the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// No stray word right after an accept
	a_quiet_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("word strobed right after accept");

	// Only minus or digit characters appear
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (char_code == CHAR_MINUS) ||
			(char_code >= CHAR_ZERO && char_code <= CHAR_ZERO + 8'd9))
		else $error("illegal character code");

	// A minus sign never ends a string
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (char_code == CHAR_MINUS) |-> !last)
		else $error("minus marked last");

	// A string in flight keeps the block busy
	a_busy_mid_string: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("idle in the middle of a string");

endmodule

bind int_to_decimal_ascii_top itda_checker u_itda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.char_code (char_code),
	.last      (last)
);
